/* hdl/permutation_rank_unrank_top_defines.svh */
// ----------------------------------------------------------------------------
// Permutation rank/unrank assertion macros
// Shared property shorthands for the checker, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_RANK_UNRANK_TOP_DEFINES_SVH
`define PERMUTATION_RANK_UNRANK_TOP_DEFINES_SVH

// same-cycle implication
`define PRRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/prru_pkg.sv */
// ----------------------------------------------------------------------------
// Permutation rank/unrank package
// Types, word layouts, ALU opcodes and the factorial table.
// ----------------------------------------------------------------------------
package prru_pkg;

  localparam int unsigned PRRU_MAX_SIZE = 20;
  localparam int unsigned ELEM_W        = 5;
  localparam int unsigned RANK_W        = 62;
  localparam int unsigned IN_TDATA_W    = 72;
  localparam int unsigned OUT_TDATA_W   = 72;

  localparam logic KIND_UNRANK = 1'b0;
  localparam logic KIND_RANK   = 1'b1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [RANK_W-1:0] a;
    logic [RANK_W-1:0] b;
  } alu_req_t;

  // co: carry out on add, borrow (a < b) on sub
  typedef struct packed {
    logic [RANK_W-1:0] res;
    logic              co;
  } alu_rsp_t;

  typedef struct packed {
    logic              kind;
    logic [ELEM_W-1:0] perm_size;
    logic [RANK_W-1:0] rank_in;
    logic [ELEM_W-1:0] element_in;
    logic              element_last;
  } item_t;

  typedef struct packed {
    logic              result_kind;
    logic [ELEM_W-1:0] element_out;
    logic [RANK_W-1:0] rank_out;
    logic              last_out;
    logic              error_flag;
  } result_t;

  function automatic logic [RANK_W-1:0] fact_f(input logic [ELEM_W-1:0] idx);
    logic [RANK_W-1:0] f;
    unique case (idx)
      5'd0:    f = 62'd1;
      5'd1:    f = 62'd1;
      5'd2:    f = 62'd2;
      5'd3:    f = 62'd6;
      5'd4:    f = 62'd24;
      5'd5:    f = 62'd120;
      5'd6:    f = 62'd720;
      5'd7:    f = 62'd5040;
      5'd8:    f = 62'd40320;
      5'd9:    f = 62'd362880;
      5'd10:   f = 62'd3628800;
      5'd11:   f = 62'd39916800;
      5'd12:   f = 62'd479001600;
      5'd13:   f = 62'd6227020800;
      5'd14:   f = 62'd87178291200;
      5'd15:   f = 62'd1307674368000;
      5'd16:   f = 62'd20922789888000;
      5'd17:   f = 62'd355687428096000;
      5'd18:   f = 62'd6402373705728000;
      5'd19:   f = 62'd121645100408832000;
      5'd20:   f = 62'd2432902008176640000;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

/* hdl/prru_alu.sv */
// ----------------------------------------------------------------------------
// Permutation rank/unrank shared ALU
// 62-bit add or compare-subtract, reused by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
module prru_alu (
  input  prru_pkg::alu_req_t req_i,
  output prru_pkg::alu_rsp_t rsp_o
);
  import prru_pkg::*;

  logic [RANK_W:0] sum;

  always_comb begin
    if (req_i.op == ALU_ADD) begin
      sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    end else begin
      sum = {1'b0, req_i.a} - {1'b0, req_i.b};
    end
  end

  assign rsp_o.res = sum[RANK_W-1:0];
  assign rsp_o.co  = sum[RANK_W];

endmodule

/* hdl/prru_core.sv */
// ----------------------------------------------------------------------------
// Permutation rank/unrank sequencer
// Steps the shared ALU through digit extraction and rank accumulation.
// ----------------------------------------------------------------------------
module prru_core #(
  parameter int unsigned MAX_SIZE = prru_pkg::PRRU_MAX_SIZE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  prru_pkg::item_t   item_i,
  output logic              item_ready_o,
  input  logic              slot_free_i,
  output logic              emit_o,
  output prru_pkg::result_t res_o
);
  import prru_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_U_CHECK,
    ST_U_DEC,
    ST_U_SCAN,
    ST_U_EMIT,
    ST_U_BAD,
    ST_R_SCAN,
    ST_R_FINAL
  } state_e;

  state_e              state_q, state_d;
  logic [ELEM_W-1:0]   n_q, n_d;
  logic [RANK_W-1:0]   k_q, k_d;
  logic [MAX_SIZE-1:0] free_q, free_d;
  logic [ELEM_W-1:0]   j_q, j_d;
  logic [ELEM_W-1:0]   val_q, val_d;
  logic [ELEM_W-1:0]   fidx_q, fidx_d;
  logic [ELEM_W-1:0]   v_q, v_d;
  logic                last_q, last_d;
  logic [MAX_SIZE-1:0] unused_q, unused_d;
  logic [RANK_W-1:0]   accum_q, accum_d;
  logic [ELEM_W-1:0]   pos_q, pos_d;
  logic                bad_q, bad_d;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  logic [31:0]         free_ext, unused_ext;
  logic [ELEM_W-1:0]   v_idx, pos_inc;
  logic                elem_ok, size_bad, fin_err;

  prru_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign free_ext     = 32'(free_q);
  assign unused_ext   = 32'(unused_q);
  assign v_idx        = item_i.element_in - 5'd1;
  assign pos_inc      = (pos_q == 5'd31) ? pos_q : pos_q + 5'd1;
  assign item_ready_o = (state_q == ST_IDLE);
  assign size_bad     = (n_q == '0) || (n_q > ELEM_W'(MAX_SIZE));
  assign fin_err      = bad_q || (pos_q != n_q);

  assign elem_ok = (item_i.perm_size != '0) && (item_i.perm_size <= ELEM_W'(MAX_SIZE)) &&
                   (pos_q < item_i.perm_size) && (item_i.element_in != '0) &&
                   (item_i.element_in <= item_i.perm_size) && unused_ext[v_idx];

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    k_d      = k_q;
    free_d   = free_q;
    j_d      = j_q;
    val_d    = val_q;
    fidx_d   = fidx_q;
    v_d      = v_q;
    last_d   = last_q;
    unused_d = unused_q;
    accum_d  = accum_q;
    pos_d    = pos_q;
    bad_d    = bad_q;
    alu_req  = '{op: ALU_SUB, a: k_q, b: fact_f(fidx_q)};
    emit_o   = 1'b0;
    res_o    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          n_d    = item_i.perm_size;
          last_d = item_i.element_last;
          if (item_i.kind == KIND_UNRANK) begin
            k_d     = item_i.rank_in;
            state_d = ST_U_CHECK;
          end else if (elem_ok) begin
            v_d     = item_i.element_in;
            j_d     = '0;
            fidx_d  = item_i.perm_size - 5'd1 - pos_q;
            state_d = ST_R_SCAN;
          end else begin
            bad_d   = 1'b1;
            pos_d   = pos_inc;
            state_d = item_i.element_last ? ST_R_FINAL : ST_IDLE;
          end
        end
      end

      // range check: n in 1..MAX_SIZE and 1 <= rank <= n!
      ST_U_CHECK: begin
        alu_req = '{op: ALU_SUB, a: fact_f(n_q), b: k_q};
        if (size_bad || (k_q == '0) || alu_rsp.co) begin
          state_d = ST_U_BAD;
        end else begin
          state_d = ST_U_DEC;
        end
      end

      ST_U_DEC: begin
        alu_req = '{op: ALU_SUB, a: k_q, b: 62'd1};
        k_d     = alu_rsp.res;
        free_d  = '1;
        j_d     = '0;
        fidx_d  = n_q - 5'd1;
        state_d = ST_U_SCAN;
      end

      // skip one free value per factorial that still fits in k
      ST_U_SCAN: begin
        if (free_ext[j_q]) begin
          if (!alu_rsp.co) begin
            k_d = alu_rsp.res;
            j_d = j_q + 5'd1;
          end else begin
            val_d   = j_q + 5'd1;
            free_d  = free_q & ~MAX_SIZE'(32'd1 << j_q);
            state_d = ST_U_EMIT;
          end
        end else begin
          j_d = j_q + 5'd1;
        end
      end

      ST_U_EMIT: begin
        if (slot_free_i) begin
          emit_o = 1'b1;
          res_o  = '{result_kind: KIND_UNRANK, element_out: val_q, rank_out: '0,
                     last_out: (fidx_q == '0), error_flag: 1'b0};
          if (fidx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            fidx_d  = fidx_q - 5'd1;
            j_d     = '0;
            state_d = ST_U_SCAN;
          end
        end
      end

      ST_U_BAD: begin
        if (slot_free_i) begin
          emit_o  = 1'b1;
          res_o   = '{result_kind: KIND_UNRANK, element_out: '0, rank_out: '0,
                      last_out: 1'b1, error_flag: 1'b1};
          state_d = ST_IDLE;
        end
      end

      // add one factorial per unused value below the element
      ST_R_SCAN: begin
        alu_req = '{op: ALU_ADD, a: accum_q, b: fact_f(fidx_q)};
        if (j_q + 5'd1 == v_q) begin
          unused_d = unused_q & ~MAX_SIZE'(32'd1 << j_q);
          pos_d    = pos_inc;
          state_d  = last_q ? ST_R_FINAL : ST_IDLE;
        end else begin
          if (unused_ext[j_q]) begin
            accum_d = alu_rsp.res;
          end
          j_d = j_q + 5'd1;
        end
      end

      ST_R_FINAL: begin
        alu_req = '{op: ALU_ADD, a: accum_q, b: 62'd1};
        if (slot_free_i) begin
          emit_o   = 1'b1;
          res_o    = '{result_kind: KIND_RANK, element_out: '0,
                       rank_out: fin_err ? '0 : alu_rsp.res,
                       last_out: 1'b1, error_flag: fin_err};
          unused_d = '1;
          accum_d  = '0;
          pos_d    = '0;
          bad_d    = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      unused_q <= '1;
      accum_q  <= '0;
      pos_q    <= '0;
      bad_q    <= 1'b0;
      n_q      <= '0;
      k_q      <= '0;
      free_q   <= '1;
      j_q      <= '0;
      val_q    <= '0;
      fidx_q   <= '0;
      v_q      <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      unused_q <= unused_d;
      accum_q  <= accum_d;
      pos_q    <= pos_d;
      bad_q    <= bad_d;
      n_q      <= n_d;
      k_q      <= k_d;
      free_q   <= free_d;
      j_q      <= j_d;
      val_q    <= val_d;
      fidx_q   <= fidx_d;
      v_q      <= v_d;
      last_q   <= last_d;
    end
  end

endmodule

/* hdl/permutation_rank_unrank_top.sv */
// ----------------------------------------------------------------------------
// Permutation rank/unrank top level
// Lehmer-code conversion between a permutation of 1..n and its rank.
// ----------------------------------------------------------------------------
// Input stream: tuser selects unrank request (0) or one element to rank (1).
//   An unrank request yields n output words, the last with tlast set; a bad
//   n or rank yields a single error word. Ranked elements give no output
//   until the element with tlast, which yields one rank word.
// Timing: the sequencer owns one 62-bit add/subtract unit and walks the
//   value mask one position per cycle. Unrank: a range check and a rank
//   decrement, then per element a scan of the mask and an output step.
//   Rank: per element an accept step and a scan up to the element's value,
//   then a final step that outputs the rank.
// tready is high only while the sequencer is idle; one item is in work.
// Results go through a one-word output register; a stalled receiver holds
//   the sequencer at its next output step.
// Reset clears the rank run (all values unused, rank zero) and the output valid.
// ----------------------------------------------------------------------------
module permutation_rank_unrank_top #(
  parameter int unsigned MAX_SIZE = prru_pkg::PRRU_MAX_SIZE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // perm_size[4:0], rank_in[66:5], element_in[71:67]
  input  logic [prru_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // kind
  input  logic                              s_axis_tuser_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // element_out[4:0], rank_out[66:5], error_flag[67], zero[71:68]
  output logic [prru_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // result_kind
  output logic                              m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);
  import prru_pkg::*;

  item_t   item;
  result_t res;
  result_t m_res_q;
  logic    m_valid_q;
  logic    emit;
  logic    slot_free;

  assign item.kind         = s_axis_tuser_i;
  assign item.perm_size    = s_axis_tdata_i[4:0];
  assign item.rank_in      = s_axis_tdata_i[66:5];
  assign item.element_in   = s_axis_tdata_i[71:67];
  assign item.element_last = s_axis_tlast_i;

  assign slot_free = !m_valid_q || m_axis_tready_i;

  prru_core #(
    .MAX_SIZE (MAX_SIZE)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid_i),
    .item_i       (item),
    .item_ready_o (s_axis_tready_o),
    .slot_free_i  (slot_free),
    .emit_o       (emit),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0000, m_res_q.error_flag, m_res_q.rank_out,
                            m_res_q.element_out};
  assign m_axis_tuser_o  = m_res_q.result_kind;
  assign m_axis_tlast_o  = m_res_q.last_out;

endmodule

/* hdl/prru_checker.sv */
// ----------------------------------------------------------------------------
// Permutation rank/unrank port checker
// Watches the result stream of the top level; bound in below.
// ----------------------------------------------------------------------------
`include "permutation_rank_unrank_top_defines.svh"

module prru_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  `PRRU_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled output word changed")

  `PRRU_ASSERT_IMP(a_rank_last, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o, "rank word without tlast")

  `PRRU_ASSERT_IMP(a_unrank_no_rank, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o[66:5] == 62'd0, "unrank word carries a rank")

  `PRRU_ASSERT_IMP(a_err_zero, m_axis_tvalid_o && m_axis_tdata_o[67], m_axis_tdata_o[66:0] == 67'd0, "error word carries data")

endmodule

bind permutation_rank_unrank_top prru_checker u_prru_checker (.*);
